@@ rtl/tdfe_pkg.sv @@
// shared types and constants for the table driven state machine engine
`default_nettype none

package tdfe_pkg;

  localparam int STATE_W     = 4;
  localparam int EVENT_W     = 8;
  localparam int EN_W        = 3;
  localparam int CFG_W       = 5;
  localparam int MAX_STATES  = 16;
  localparam int MAX_TRANS   = 8;
  localparam int TI_W        = $clog2(MAX_TRANS);
  localparam int LEN_W       = $clog2(MAX_TRANS + 1);
  localparam int TBL_AW      = STATE_W + TI_W;
  localparam int CMD_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
  localparam logic [EN_W-1:0]  EN_RESET  = '1;

  // action enable bit positions
  localparam int EN_ENTRY   = 0;
  localparam int EN_ROUTINE = 1;
  localparam int EN_EXIT    = 2;

  typedef enum logic [1:0] {
    OP_EVENT   = 2'd0,
    OP_ADD     = 2'd1,
    OP_SET_EN  = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    NK_ENTRY   = 3'd0,
    NK_ROUTINE = 3'd1,
    NK_EXIT    = 3'd2,
    NK_OK      = 3'd3,
    NK_REJECT  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_SRCH,
    BK_NOTE,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    op_t                operation;
    logic [EVENT_W-1:0] event_code;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [EN_W-1:0]    action_enables;
  } in_item_t;

  typedef struct packed {
    kind_t              notice_kind;
    logic [STATE_W-1:0] notice_state;
    logic               last;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t                op;
    logic               in_range;
    logic [EVENT_W-1:0] event_code;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [EN_W-1:0]    action_enables;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/table_driven_fsm_engine_top.sv @@
// top level of the table driven state machine engine
//
// Programmable state machine. Input beats go in through a queue port
// (in_push/in_full): an event, an add of a transition, a set of a state's
// action enables, or a restart. Results leave through a queue port
// (out_empty/out_pop); each input beat gives zero to four results and the
// final one carries last. The state count register is written through
// cfg_valid/cfg_ready, which is always ready.
// A front stage classifies beats and range-checks states into a command
// queue; a back sequencer executes one command at a time. A load is taken
// in the idle state and gives its one result from the load state. An event
// is taken in the idle state; its state's list is then searched with one
// table read per cycle (up to 8 entries), each compared in the cycle after
// its read, until a match or the list's end; the notice state works out the
// notices and the emit state sends them, the final one with last. Load and
// emit wait while the result queue is full. The back sequencer sets the
// throughput. Reset clears the lists and the machine, sets all action
// enables and the state count to 16; no clearing pass is needed. When the
// receiver stops popping, the result queue fills, the sequencer waits, then
// the command queue fills and in_full rises; nothing is lost.
`default_nettype none

module table_driven_fsm_engine_top
  import tdfe_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_Q_DEPTH,
  parameter int RES_DEPTH = RES_Q_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_push,
  input  wire in_item_t         in_data,
  output logic                  in_full,
  input  wire logic             out_pop,
  output out_item_t             out_data,
  output logic                  out_empty
);

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(out_item_t);

  cmd_t             front_cmd, back_cmd;
  logic [CMD_W-1:0] cmd_q_rdata;
  logic             cmd_empty, cmd_pop;
  out_item_t        res_data;
  logic [RES_W-1:0] res_q_rdata;
  logic             res_full, res_push;

  // classify incoming beats
  tdfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd_data  (front_cmd)
  );

  // command queue between front and back
  tdfe_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_cmd),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_q_rdata),
    .empty (cmd_empty)
  );

  assign back_cmd = cmd_t'(cmd_q_rdata);

  // execute commands
  tdfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (back_cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // result queue
  tdfe_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_q_rdata),
    .empty (out_empty)
  );

  assign out_data = out_item_t'(res_q_rdata);

endmodule

`default_nettype wire

@@ rtl/tdfe_fifo.sv @@
// small first-word-fall-through queue of packed words
`default_nettype none

module tdfe_fifo
  import tdfe_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  // status and pointer advance
  always_comb begin
    full       = (cnt_r == CW'(DEPTH));
    empty      = (cnt_r == '0);
    do_push    = push && !full;
    do_pop     = pop && !empty;
    rdata      = mem_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tdfe_front.sv @@
// front end: state count register and classification of incoming beats
`default_nettype none

module tdfe_front
  import tdfe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire in_item_t         in_data,
  output cmd_t                  cmd_data
);

  logic [CFG_W-1:0] states_in_use_r;
  logic             from_ok, to_ok;

  assign cfg_ready = 1'b1;

  // state count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      states_in_use_r <= CFG_RESET;
    end else if (cfg_valid) begin
      states_in_use_r <= cfg_data;
    end
  end

  // range check against the state count
  always_comb begin
    from_ok = {1'b0, in_data.from_state} < states_in_use_r;
    to_ok   = {1'b0, in_data.to_state} < states_in_use_r;
    cmd_data.op             = in_data.operation;
    cmd_data.event_code     = in_data.event_code;
    cmd_data.from_state     = in_data.from_state;
    cmd_data.to_state       = in_data.to_state;
    cmd_data.action_enables = in_data.action_enables;
    case (in_data.operation)
      OP_ADD:    cmd_data.in_range = from_ok && to_ok;
      OP_SET_EN: cmd_data.in_range = from_ok;
      default:   cmd_data.in_range = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/tdfe_back.sv @@
// back end: transition table, action enables and the event sequencer
`default_nettype none

module tdfe_back
  import tdfe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cmd_empty,
  input  wire cmd_t  cmd_data,
  output logic       cmd_pop,
  input  wire logic  res_full,
  output logic       res_push,
  output out_item_t  res_data
);

  typedef struct packed {
    logic [EVENT_W-1:0] ev;
    logic [STATE_W-1:0] dest;
  } tbl_entry_t;

  bk_state_t          state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [STATE_W-1:0] cur_r, cur_nxt;
  logic [STATE_W-1:0] new_r, new_nxt;
  logic [STATE_W-1:0] old_r, old_nxt;
  logic               entered_r, entered_nxt;
  logic [LEN_W-1:0]   idx_r, idx_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [EN_W-1:0]    en_old_r, en_old_nxt;
  logic [3:0]         mask_r, mask_nxt;

  logic [LEN_W-1:0]   len_r [MAX_STATES];
  logic [EN_W-1:0]    en_r  [MAX_STATES];
  tbl_entry_t         mem_r [1 << TBL_AW];
  tbl_entry_t         tbl_rd_r;

  logic [STATE_W-1:0] len_raddr, en_raddr;
  logic [LEN_W-1:0]   len_rd;
  logic [EN_W-1:0]    en_rd;
  logic               len_we, en_we, mem_we;
  logic [TBL_AW-1:0]  mem_waddr, mem_raddr;
  tbl_entry_t         mem_wdata;
  logic               issue, add_ok, diff;
  logic [3:0]         low_bit;

  // single read port on each small array
  always_comb begin
    len_raddr = (state_r == BK_LOAD) ? cmd_r.from_state : cur_r;
    en_raddr  = (state_r == BK_NOTE) ? new_r : cur_r;
    len_rd    = len_r[len_raddr];
    en_rd     = en_r[en_raddr];
    low_bit   = mask_r & (~mask_r + 4'd1);
  end

  // sequencer next state and outputs
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    cur_nxt     = cur_r;
    new_nxt     = new_r;
    old_nxt     = old_r;
    entered_nxt = entered_r;
    idx_nxt     = idx_r;
    rd_vld_nxt  = 1'b0;
    en_old_nxt  = en_old_r;
    mask_nxt    = mask_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res_data    = '0;
    len_we      = 1'b0;
    en_we       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = {cmd_r.from_state, len_rd[TI_W-1:0]};
    mem_wdata   = '{ev: cmd_r.event_code, dest: cmd_r.to_state};
    mem_raddr   = {cur_r, idx_r[TI_W-1:0]};
    issue       = 1'b0;
    add_ok      = cmd_r.in_range && (len_rd < LEN_W'(MAX_TRANS));
    diff        = new_r != cur_r;
    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          cmd_nxt    = cmd_data;
          en_old_nxt = en_rd;
          new_nxt    = cur_r;
          idx_nxt    = '0;
          state_nxt  = (cmd_data.op == OP_EVENT) ? BK_SRCH : BK_LOAD;
        end
      end
      BK_LOAD: begin
        if (!res_full) begin
          res_push              = 1'b1;
          res_data.last         = 1'b1;
          res_data.notice_state = cmd_r.from_state;
          res_data.notice_kind  = NK_REJECT;
          case (cmd_r.op)
            OP_ADD: begin
              if (add_ok) begin
                mem_we               = 1'b1;
                len_we               = 1'b1;
                res_data.notice_kind = NK_OK;
              end
            end
            OP_SET_EN: begin
              if (cmd_r.in_range) begin
                en_we                = 1'b1;
                res_data.notice_kind = NK_OK;
              end
            end
            OP_RESTART: begin
              cur_nxt               = '0;
              new_nxt               = '0;
              entered_nxt           = 1'b0;
              res_data.notice_kind  = NK_OK;
              res_data.notice_state = '0;
            end
            default: begin
              res_data.notice_kind = NK_REJECT;
            end
          endcase
          state_nxt = BK_IDLE;
        end
      end
      BK_SRCH: begin
        // one table read per cycle, compared in the cycle after the read
        issue = idx_r < len_rd;
        if (rd_vld_r && (tbl_rd_r.ev == cmd_r.event_code)) begin
          new_nxt   = tbl_rd_r.dest;
          state_nxt = BK_NOTE;
        end else if (!issue && !rd_vld_r) begin
          state_nxt = BK_NOTE;
        end else begin
          rd_vld_nxt = issue;
          idx_nxt    = idx_r + LEN_W'(issue);
        end
      end
      BK_NOTE: begin
        // slots: entry old, exit old, entry new, routine new
        mask_nxt[0] = !entered_r && en_old_r[EN_ENTRY];
        mask_nxt[1] = diff && en_old_r[EN_EXIT];
        mask_nxt[2] = diff && en_rd[EN_ENTRY];
        mask_nxt[3] = diff ? en_rd[EN_ROUTINE] : en_old_r[EN_ROUTINE];
        old_nxt     = cur_r;
        cur_nxt     = new_r;
        entered_nxt = 1'b1;
        state_nxt   = BK_EMIT;
      end
      BK_EMIT: begin
        if (mask_r == '0) begin
          state_nxt = BK_IDLE;
        end else if (!res_full) begin
          res_push      = 1'b1;
          res_data.last = (mask_r & ~low_bit) == '0;
          if (low_bit[0]) begin
            res_data.notice_kind  = NK_ENTRY;
            res_data.notice_state = old_r;
          end else if (low_bit[1]) begin
            res_data.notice_kind  = NK_EXIT;
            res_data.notice_state = old_r;
          end else if (low_bit[2]) begin
            res_data.notice_kind  = NK_ENTRY;
            res_data.notice_state = cur_r;
          end else begin
            res_data.notice_kind  = NK_ROUTINE;
            res_data.notice_state = cur_r;
          end
          mask_nxt = mask_r & ~low_bit;
          if (res_data.last) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // control registers and per-state lengths and enables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      cur_r     <= '0;
      new_r     <= '0;
      old_r     <= '0;
      entered_r <= 1'b0;
      idx_r     <= '0;
      rd_vld_r  <= 1'b0;
      mask_r    <= '0;
      for (int i = 0; i < MAX_STATES; i++) begin
        len_r[i] <= '0;
        en_r[i]  <= EN_RESET;
      end
    end else begin
      state_r   <= state_nxt;
      cur_r     <= cur_nxt;
      new_r     <= new_nxt;
      old_r     <= old_nxt;
      entered_r <= entered_nxt;
      idx_r     <= idx_nxt;
      rd_vld_r  <= rd_vld_nxt;
      mask_r    <= mask_nxt;
      if (len_we) begin
        len_r[cmd_r.from_state] <= len_rd + LEN_W'(1);
      end
      if (en_we) begin
        en_r[cmd_r.from_state] <= cmd_r.action_enables;
      end
    end
  end

  // command payload
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    en_old_r <= en_old_nxt;
  end

  // transition table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    tbl_rd_r <= mem_r[mem_raddr];
  end

endmodule

`default_nettype wire
